FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rms_pkg.sv
// types and constants of the rate monotonic scheduler
package rms_pkg;

	// opcodes of a request transaction
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_TASK_COUNT = 1'b0;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int TCNT_W = 5;

	// one task record as held in the table memory
	typedef struct packed {
		logic [15:0] exec_time;
		logic [15:0] period;
		logic [15:0] remaining;
		logic [31:0] next_rel;
	} rms_rec_t;

endpackage

FILE: rtl/rate_monotonic_scheduler_unit.sv
// rate monotonic scheduler top level: control, arithmetic and config port
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | opcode, task_index, exec_time, period
//  rsp     | out       | rsp_valid/stall   | idle .. current_time, one per tick
//  apb     | in        | psel/penable      | task_count at byte address 0
//
// a load transaction gives no response
// a tick scans the first limit entries, one table entry a cycle (limit is task_count
// capped at MAX_TASKS), skipped when limit is 0, then drains, updates and finishes
// arst_n clears the table valid bits, counters, sums and the last choice
// rsp holds while rsp_stall is high; a finished tick waits in its last state until
// the response register is free, and req_stall stays high meanwhile
`include "assert_macros.svh"

module rate_monotonic_scheduler_unit #(
	parameter int MAX_TASKS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           opcode,
	input  logic [3:0]                     task_index,
	input  logic [15:0]                    exec_time,
	input  logic [15:0]                    period,
	// response channel
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic                           idle,
	output logic [3:0]                     running_task,
	output logic                           switched,
	output logic                           job_done,
	output logic [31:0]                    completion_time,
	output logic [31:0]                    turnaround,
	output logic [31:0]                    waiting,
	output logic [47:0]                    waiting_sum,
	output logic [47:0]                    turnaround_sum,
	output logic [31:0]                    current_time,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rms_pkg::PADDR_W-1:0]    paddr,
	input  logic [rms_pkg::PDATA_W-1:0]    pwdata,
	output logic [rms_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import rms_pkg::*;

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DRAIN, S_UPD_A, S_UPD_B, S_UPD_C, S_FIN
	} state_t;

	state_t              state_q;
	logic [TCNT_W-1:0]   task_count_q;
	logic [CNT_W-1:0]    limit;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic [CNT_W-1:0]    rd_nxt;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	logic                found_q;
	logic [IDX_W-1:0]    best_idx_q;
	rms_rec_t            best_rec_q;
	logic                done_q;
	logic [15:0]         rem_q;
	logic [31:0]         tick_q;
	logic [31:0]         ct_q;
	logic [31:0]         tat_q;
	logic [31:0]         wt_q;
	logic [47:0]         wsum_q;
	logic [47:0]         tsum_q;

	logic                last_none_q;
	logic                last_idle_q;
	logic [IDX_W-1:0]    last_idx_q;
	logic                sw;

	logic                rsp_valid_q;
	logic                idle_q;
	logic [3:0]          running_q;
	logic                switched_q;
	logic                job_done_q;
	logic [31:0]         ct_out_q;
	logic [31:0]         tat_out_q;
	logic [31:0]         wt_out_q;
	logic [47:0]         wsum_out_q;
	logic [47:0]         tsum_out_q;
	logic [31:0]         time_out_q;

	logic                req_acc;
	logic                load_ok;
	logic                cand;
	logic                apb_wr;

	logic                tbl_we;
	logic [IDX_W-1:0]    tbl_waddr;
	rms_rec_t            tbl_wdata;
	logic                tbl_re;
	rms_rec_t            tbl_rdata;

	// handshake and load decode
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign load_ok   = req_acc && (opcode == OP_LOAD) && (32'(task_index) < MAX_TASKS);

	// number of entries taking part, saturated to the table depth
	always_comb begin
		if (32'(task_count_q) > MAX_TASKS) begin
			limit = CNT_W'(MAX_TASKS);
		end else begin
			limit = CNT_W'(task_count_q);
		end
	end

	assign rd_nxt = rd_cnt_q + CNT_W'(1);

	// table port selection: loads, scan reads, job write-back
	always_comb begin
		tbl_re    = (state_q == S_SCAN);
		tbl_we    = 1'b0;
		tbl_waddr = IDX_W'(task_index);
		tbl_wdata = '{exec_time: exec_time, period: period,
			remaining: exec_time, next_rel: 32'd0};
		if (load_ok) begin
			tbl_we = 1'b1;
		end else if (state_q == S_UPD_C && found_q) begin
			tbl_we    = 1'b1;
			tbl_waddr = best_idx_q;
			tbl_wdata = best_rec_q;
			if (done_q) begin
				tbl_wdata.remaining = best_rec_q.exec_time;
				tbl_wdata.next_rel  = best_rec_q.next_rel + 32'(best_rec_q.period);
			end else begin
				tbl_wdata.remaining = rem_q;
			end
		end
	end

	rms_table #(
		.DEPTH (MAX_TASKS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (tbl_wdata),
		.re     (tbl_re),
		.raddr  (rd_cnt_q[IDX_W-1:0]),
		.rdata  (tbl_rdata)
	);

	// released task with work left
	assign cand = rd_vld_s1 && (tick_q >= tbl_rdata.next_rel) && (tbl_rdata.remaining != 16'd0);

	// choice differs from the previous tick
	assign sw = last_none_q ||
		(found_q ? (last_idle_q || (last_idx_q != best_idx_q)) : !last_idle_q);

	// sequencer, arithmetic and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= '0;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			done_q      <= 1'b0;
			tick_q      <= '0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			last_none_q <= 1'b1;
			last_idle_q <= 1'b0;
			last_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= tbl_re;
			rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end

			// keep the best candidate seen so far
			if (cand && (!found_q || tbl_rdata.period < best_rec_q.period)) begin
				found_q    <= 1'b1;
				best_idx_q <= rd_idx_s1;
				best_rec_q <= tbl_rdata;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc && opcode == OP_TICK) begin
						found_q  <= 1'b0;
						done_q   <= 1'b0;
						limit_q  <= limit;
						rd_cnt_q <= '0;
						ct_q     <= tick_q + 32'd1;
						state_q  <= (limit == '0) ? S_UPD_A : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_cnt_q <= rd_nxt;
					if (rd_nxt == limit_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPD_A;
				end
				S_UPD_A: begin
					rem_q   <= best_rec_q.remaining - 16'd1;
					tat_q   <= ct_q - best_rec_q.next_rel;
					state_q <= S_UPD_B;
				end
				S_UPD_B: begin
					done_q  <= found_q && (rem_q == 16'd0);
					wt_q    <= tat_q - 32'(best_rec_q.exec_time);
					state_q <= S_UPD_C;
				end
				S_UPD_C: begin
					if (done_q) begin
						tsum_q <= tsum_q + 48'(tat_q);
						wsum_q <= wsum_q + 48'(wt_q);
					end
					tick_q  <= ct_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						idle_q      <= !found_q;
						running_q   <= found_q ? 4'(best_idx_q) : 4'd0;
						switched_q  <= sw;
						job_done_q  <= done_q;
						ct_out_q    <= done_q ? ct_q : 32'd0;
						tat_out_q   <= done_q ? tat_q : 32'd0;
						wt_out_q    <= done_q ? wt_q : 32'd0;
						wsum_out_q  <= wsum_q;
						tsum_out_q  <= tsum_q;
						time_out_q  <= tick_q;
						last_none_q <= 1'b0;
						last_idle_q <= !found_q;
						last_idx_q  <= best_idx_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign idle            = idle_q;
	assign running_task    = running_q;
	assign switched        = switched_q;
	assign job_done        = job_done_q;
	assign completion_time = ct_out_q;
	assign turnaround      = tat_out_q;
	assign waiting         = wt_out_q;
	assign waiting_sum     = wsum_out_q;
	assign turnaround_sum  = tsum_out_q;
	assign current_time    = time_out_q;

	// configuration register
	assign apb_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
		end else if (apb_wr && paddr[2] == REG_TASK_COUNT) begin
			task_count_q <= pwdata[TCNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TASK_COUNT) ? PDATA_W'(task_count_q) : '0;

	`ASSERT_IMPLY(a_scan_no_write, state_q == S_SCAN || state_q == S_DRAIN, !tbl_we, "write in scan")
	`ASSERT_IMPLY(a_best_in_range, found_q, CNT_W'(best_idx_q) < limit_q, "choice beyond limit")
	`ASSERT_NEXT(a_tick_step, state_q == S_UPD_C, tick_q == $past(tick_q) + 32'd1, "tick skipped")
	`ASSERT_IMPLY(a_done_not_idle, rsp_valid_q && job_done_q, !idle_q, "done on idle tick")

endmodule

FILE: rtl/rms_table.sv
// task table memory with per-entry valid bits and registered read
`include "assert_macros.svh"

module rms_table #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  rms_pkg::rms_rec_t          wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output rms_pkg::rms_rec_t          rdata
);
	import rms_pkg::*;

	rms_rec_t          mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	rms_rec_t          rdata_s1;
	logic              rvalid_s1;

	// storage array, written and read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// valid bits, an entry never loaded reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_s1 <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_s1 ? rdata_s1 : '0;

	`ASSERT_ALWAYS(a_no_rw_overlap, !(we && re), "table read and write in one cycle")
	`ASSERT_NEXT(a_write_sets_valid, we, valid_q != '0, "valid bit not set after write")
	`ASSERT_IMPLY(a_invalid_reads_zero, !rvalid_s1, rdata == '0, "unloaded entry not zero")

endmodule

FILE: verif/rms_checker.sv
// scheduler checker: predicts each tick response from observed transactions and compares
`timescale 1ns / 100ps

module rms_checker #(
	parameter int MAX_TASKS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  logic                        opcode,
	input  logic [3:0]                  task_index,
	input  logic [15:0]                 exec_time,
	input  logic [15:0]                 period,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  logic                        idle,
	input  logic [3:0]                  running_task,
	input  logic                        switched,
	input  logic                        job_done,
	input  logic [31:0]                 completion_time,
	input  logic [31:0]                 turnaround,
	input  logic [31:0]                 waiting,
	input  logic [47:0]                 waiting_sum,
	input  logic [47:0]                 turnaround_sum,
	input  logic [31:0]                 current_time,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rms_pkg::PADDR_W-1:0] paddr,
	input  logic [rms_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          failures,
	output int                          outstanding
);
	import rms_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_TASK_COUNT = {REG_TASK_COUNT, 2'b00};
	localparam logic [4:0] CHOICE_IDLE = 5'd16;
	localparam logic [4:0] CHOICE_NONE = 5'd17;

	typedef struct packed {
		logic        idle;
		logic [3:0]  running_task;
		logic        switched;
		logic        job_done;
		logic [31:0] completion_time;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [47:0] waiting_sum;
		logic [47:0] turnaround_sum;
		logic [31:0] current_time;
	} tick_report_t;

	// mirror of the task table and scheduler counters
	logic [15:0] exec_tbl [MAX_TASKS];
	logic [15:0] period_tbl [MAX_TASKS];
	logic [15:0] work_left [MAX_TASKS];
	logic [31:0] release_at [MAX_TASKS];
	logic [31:0] tick_count;
	logic [47:0] wait_total;
	logic [47:0] tat_total;
	logic [4:0]  prev_choice;
	logic [TCNT_W-1:0] sched_count;

	tick_report_t tick_reports_due [$];
	tick_report_t due;
	tick_report_t seen;
	int fail_count = 0;

	task automatic report_failure(string msg);
		if (fail_count < 100)
			$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
		if (got !== want)
			report_failure($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// one tick of rate monotonic choice, run accounting and re-arming
	function automatic tick_report_t schedule_tick();
		tick_report_t r;
		int lim;
		logic found;
		logic [3:0] best;
		logic [15:0] best_per;
		logic [4:0] choice;
		r = '0;
		found = 1'b0;
		best = '0;
		best_per = '0;
		lim = (sched_count > MAX_TASKS) ? MAX_TASKS : int'(sched_count);
		for (int i = 0; i < lim; i++) begin
			if (tick_count >= release_at[i] && work_left[i] != 0 &&
					(!found || period_tbl[i] < best_per)) begin
				found = 1'b1;
				best = 4'(i);
				best_per = period_tbl[i];
			end
		end
		choice = found ? {1'b0, best} : CHOICE_IDLE;
		r.switched = (choice != prev_choice);
		prev_choice = choice;
		tick_count = tick_count + 32'd1;
		r.idle = !found;
		r.running_task = found ? best : 4'd0;
		if (found) begin
			work_left[best] = work_left[best] - 16'd1;
			if (work_left[best] == 0) begin
				r.job_done = 1'b1;
				r.completion_time = tick_count;
				r.turnaround = tick_count - release_at[best];
				r.waiting = r.turnaround - {16'd0, exec_tbl[best]};
				wait_total = wait_total + {16'd0, r.waiting};
				tat_total = tat_total + {16'd0, r.turnaround};
				release_at[best] = release_at[best] + {16'd0, period_tbl[best]};
				work_left[best] = exec_tbl[best];
			end
		end
		r.waiting_sum = wait_total;
		r.turnaround_sum = tat_total;
		r.current_time = tick_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				exec_tbl[i] = '0;
				period_tbl[i] = '0;
				work_left[i] = '0;
				release_at[i] = '0;
			end
			tick_count = '0;
			wait_total = '0;
			tat_total = '0;
			prev_choice = CHOICE_NONE;
			sched_count = '0;
			tick_reports_due.delete();
			failures <= 0;
			outstanding <= 0;
		end else begin
			// response side first: a response can never belong to a tick taken at this edge
			if (rsp_valid && !rsp_stall) begin
				seen = '{idle, running_task, switched, job_done, completion_time, turnaround,
					waiting, waiting_sum, turnaround_sum, current_time};
				if (tick_reports_due.size() == 0) begin
					report_failure("response transaction with no tick waiting");
				end else begin
					due = tick_reports_due.pop_front();
					check_field("idle", seen.idle, due.idle);
					check_field("running_task", seen.running_task, due.running_task);
					check_field("switched", seen.switched, due.switched);
					check_field("job_done", seen.job_done, due.job_done);
					check_field("completion_time", seen.completion_time, due.completion_time);
					check_field("turnaround", seen.turnaround, due.turnaround);
					check_field("waiting", seen.waiting, due.waiting);
					check_field("waiting_sum", seen.waiting_sum, due.waiting_sum);
					check_field("turnaround_sum", seen.turnaround_sum, due.turnaround_sum);
					check_field("current_time", seen.current_time, due.current_time);
				end
			end
			// register writes
			if (psel && penable && pwrite && pready && paddr == ADDR_TASK_COUNT)
				sched_count = pwdata[TCNT_W-1:0];
			// request transactions
			if (req_valid && !req_stall) begin
				if (opcode == OP_LOAD) begin
					exec_tbl[task_index] = exec_time;
					period_tbl[task_index] = period;
					work_left[task_index] = exec_time;
					release_at[task_index] = '0;
				end else begin
					tick_reports_due.push_back(schedule_tick());
				end
			end
			failures <= fail_count;
			outstanding <= tick_reports_due.size();
		end
	end

endmodule

FILE: verif/tb_rate_monotonic_scheduler_unit.sv
// testbench top: stimulus, handshake pacing and verdict for the scheduler unit
`timescale 1ns / 100ps

module tb_rate_monotonic_scheduler_unit;
	import rms_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_TASK_COUNT = {REG_TASK_COUNT, 2'b00};
	localparam int LATENCY_PAD = 40;
	localparam int DRAIN_LIMIT = 200000;
	localparam int ITEM_TARGET = 1050;

	typedef enum int {RX_FREE, RX_RANDOM, RX_HOLD} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               opcode = OP_TICK;
	logic [3:0]         task_index = '0;
	logic [15:0]        exec_time = '0;
	logic [15:0]        period = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic               idle;
	logic [3:0]         running_task;
	logic               switched;
	logic               job_done;
	logic [31:0]        completion_time;
	logic [31:0]        turnaround;
	logic [31:0]        waiting;
	logic [47:0]        waiting_sum;
	logic [47:0]        turnaround_sum;
	logic [31:0]        current_time;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 failures;
	int                 outstanding;

	logic [15:0] loaded = '0;
	int loads_sent = 0;
	int ticks_sent = 0;
	int settings_done = 0;
	int burst_left = 0;

	rate_monotonic_scheduler_unit dut (.*);
	rms_checker sched_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one request transaction and hold it until taken
	task automatic send_item(logic op, logic [3:0] idx, logic [15:0] ex, logic [15:0] per);
		req_valid <= 1'b1;
		opcode <= op;
		task_index <= idx;
		exec_time <= ex;
		period <= per;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (op == OP_LOAD) begin
			loaded[idx] = 1'b1;
			loads_sent++;
		end else begin
			ticks_sent++;
		end
	endtask

	// tick with random noise in the unused fields
	task automatic tick();
		send_item(OP_TICK, 4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
	endtask

	task automatic sender_gap(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// pause until every response is back, then let any load in flight finish
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic write_reg(int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_TASK_COUNT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// mostly short jobs and periods so that jobs finish, with the odd extreme
	task automatic pick_load(output logic [15:0] ex, output logic [15:0] per);
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			ex = 16'($urandom_range(1, 6));
		else if (r < 78)
			ex = '0;
		else if (r < 93)
			ex = 16'($urandom_range(7, 300));
		else
			ex = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (r < 60)
			per = 16'($urandom_range(1, 16));
		else if (r < 82)
			per = 16'($urandom_range(17, 200));
		else if (r < 95)
			per = 16'($urandom_range(1, 65535));
		else
			per = 16'hFFFF;
	endtask

	// new task count, written while idle; entries in range get loaded before any tick
	task automatic set_task_count(int value);
		logic [15:0] ex, per;
		int lim;
		wait_for_drain();
		write_reg(value);
		settings_done++;
		lim = (value > 16) ? 16 : value;
		for (int i = 0; i < lim; i++) begin
			if (!loaded[i]) begin
				pick_load(ex, per);
				send_item(OP_LOAD, 4'(i), ex, per);
			end
		end
	endtask

	task automatic random_item();
		logic [15:0] ex, per;
		if ($urandom_range(0, 99) < 75) begin
			tick();
		end else begin
			pick_load(ex, per);
			send_item(OP_LOAD, 4'($urandom_range(0, 15)), ex, per);
		end
	endtask

	// bursts of random length, some long ones with no gaps at all
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0)
				sender_gap($urandom_range(1, 12));
		end
		burst_left--;
	endtask

	// response side: free, random and long hold-off stretches
	initial begin
		rx_mode_t mode;
		int seg_len;
		int seg_no;
		seg_no = 0;
		wait (arst_n);
		forever begin
			if (seg_no == 3 || $urandom_range(0, 9) == 0) begin
				mode = RX_HOLD;
				seg_len = 300;
			end else begin
				mode = ($urandom_range(0, 1) == 0) ? RX_FREE : RX_RANDOM;
				seg_len = $urandom_range(20, 200);
			end
			for (int c = 0; c < seg_len; c++) begin
				@(posedge clk);
				case (mode)
					RX_FREE: rsp_stall <= 1'b0;
					RX_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 40);
					default: rsp_stall <= 1'b1;
				endcase
			end
			seg_no++;
		end
	end

	// stimulus and verdict
	initial begin
		int phase_len;
		int tc;
		int drain_wait;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no tasks in play: idle ticks, first one counts as a switch
		tick();
		tick();
		// equal periods, zero execution time, zero period
		send_item(OP_LOAD, 4'd0, 16'd1, 16'd4);
		send_item(OP_LOAD, 4'd1, 16'd0, 16'd1);
		send_item(OP_LOAD, 4'd2, 16'd2, 16'd4);
		send_item(OP_LOAD, 4'd3, 16'd1, 16'd0);
		set_task_count(4);
		tick();
		tick();
		tick();
		// retire the zero period task, let the tie between entries 0 and 2 play out
		send_item(OP_LOAD, 4'd3, 16'd0, 16'hFFFF);
		tick();
		tick();
		tick();
		// reload in the middle of a job
		send_item(OP_LOAD, 4'd2, 16'd3, 16'd8);
		tick();
		send_item(OP_LOAD, 4'd2, 16'd3, 16'd8);
		tick();
		// largest entry and fields, task count above the table size
		send_item(OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
		set_task_count(31);
		tick();
		tick();

		// random phases over a spread of task counts
		for (int ph = 0; loads_sent + ticks_sent < ITEM_TARGET; ph++) begin
			case (ph)
				0: tc = 16;
				1: tc = 1;
				2: tc = 17;
				3: tc = 0;
				default: tc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
					: $urandom_range(2, 16);
			endcase
			set_task_count(tc);
			phase_len = $urandom_range(40, 120);
			for (int k = 0; k < phase_len; k++) begin
				if (k == phase_len / 2 && (ph == 1 || $urandom_range(0, 2) == 0))
					wait_for_drain();
				else
					pace_sender();
				random_item();
			end
		end

		// wind down
		req_valid <= 1'b0;
		drain_wait = 0;
		do begin
			@(posedge clk);
			drain_wait++;
		end while (outstanding != 0 && drain_wait < DRAIN_LIMIT);
		repeat (LATENCY_PAD) @(posedge clk);
		$display("covered %0d loads and %0d ticks over %0d task count settings", loads_sent,
			ticks_sent, settings_done);
		$display("settings took in 0, 4, 16 and values past the table size");
		if (failures == 0 && outstanding == 0)
			$display("PASS rate_monotonic_scheduler_unit");
		else
			$display("FAIL rate_monotonic_scheduler_unit");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("FAIL rate_monotonic_scheduler_unit");
		$finish;
	end

endmodule

FILE: rate_monotonic_scheduler_unit.f
+incdir+rtl
rtl/rms_pkg.sv
rtl/rms_table.sv
rtl/rate_monotonic_scheduler_unit.sv
verif/rms_checker.sv
verif/tb_rate_monotonic_scheduler_unit.sv
